[hdl/tlc_pkg.sv]
package tlc_pkg;

  localparam int unsigned BlockBytesLog2 = 6;
  localparam int unsigned L1SetsLog2     = 6;
  localparam int unsigned L1WaysLog2     = 2;
  localparam int unsigned L2SetsLog2     = 8;
  localparam int unsigned L2WaysLog2     = 3;
  localparam int unsigned AddressBits    = 32;

  localparam int unsigned L1Ways   = 1 << L1WaysLog2;
  localparam int unsigned L2Ways   = 1 << L2WaysLog2;
  localparam int unsigned BlockW   = AddressBits - BlockBytesLog2;
  localparam int unsigned L1TagW   = BlockW - L1SetsLog2;
  localparam int unsigned L2TagW   = BlockW - L2SetsLog2;
  localparam int unsigned L1RankW  = (L1WaysLog2 > 0) ? L1WaysLog2 : 1;
  localparam int unsigned L2RankW  = (L2WaysLog2 > 0) ? L2WaysLog2 : 1;
  localparam int unsigned L1SetW   = (L1SetsLog2 > 0) ? L1SetsLog2 : 1;
  localparam int unsigned L2SetW   = (L2SetsLog2 > 0) ? L2SetsLog2 : 1;

  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 10;
  localparam int unsigned LatW     = 10;
  localparam int unsigned CycW     = 12;
  localparam int unsigned InDataW  = 32;
  localparam int unsigned OutDataW = 24;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_L1_LAT = 2'd0,
    CFG_L2_LAT = 2'd1,
    CFG_MEM_LAT = 2'd2,
    CFG_WR_ALLOC = 2'd3
  } cfg_idx_e;

  // one line of a set as stored in a memory row
  typedef struct packed {
    logic              valid;
    logic              dirty;
    logic [L1TagW-1:0] tag;
    logic [L1RankW-1:0] rank;
  } l1_line_t;

  typedef struct packed {
    logic              valid;
    logic              dirty;
    logic [L2TagW-1:0] tag;
    logic [L2RankW-1:0] rank;
  } l2_line_t;

  typedef l1_line_t [L1Ways-1:0] l1_row_t;
  typedef l2_line_t [L2Ways-1:0] l2_row_t;

  typedef struct packed {
    logic              l1_hit;
    logic              l2_hit;
    logic              l1_wb;
    logic              l2_wb;
    logic              binv;
    logic [1:0]        mem;
    logic [CycW-1:0]   cycles;
  } report_t;

endpackage

[hdl/two_level_cache_controller.sv]
// Two-level inclusive write-back cache tag controller. Each accepted word on
// s_axis (mode in tuser, byte address in tdata) is looked up in the first level
// and on a miss in the second; fills, LRU rank updates, dirty writebacks and
// back-invalidations are applied, and one report word leaves on m_axis. Both
// levels keep a whole set (tag, valid, dirty, rank of every way) in one row of
// a synchronous single-port memory; victim pointers are recomputed from the
// ranks. An access steps through the registered row reads of the two memories:
// a first-level hit ends after the first-level check, while a miss goes on to
// the second level and may evict a second-level line and write back a dirty
// first-level line. After reset both memories are swept clear, one row of
// each per cycle until that memory's rows are done, while s_axis_tready
// stays low; configuration writes are taken during the sweep and between
// accesses, and a pending configuration write holds off a new access. A new
// access is taken once the previous report has been handed to the output
// register.
module two_level_cache_controller (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [tlc_pkg::InDataW-1:0]   s_axis_tdata,   // address[31:0]
  input  logic                          s_axis_tuser,   // mode
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // l1_hit, l2_hit, l1_writeback, l2_writeback, back_invalidate,
  // memory_accesses[1:0], access_cycles[11:0], zero fill
  output logic [tlc_pkg::OutDataW-1:0]  m_axis_tdata,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [tlc_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  logic [tlc_pkg::CfgDataW-1:0]  cfg_data_i
);
  import tlc_pkg::*;

  localparam int unsigned L1Rows = 1 << L1SetsLog2;
  localparam int unsigned L2Rows = 1 << L2SetsLog2;
  localparam int unsigned ClrRows = (L1Rows > L2Rows) ? L1Rows : L2Rows;
  localparam int unsigned ClrW = $clog2(ClrRows + 1);

  typedef enum logic [9:0] {
    ST_CLEAR  = 10'b0000000001,
    ST_IDLE   = 10'b0000000010,
    ST_RD1    = 10'b0000000100, // l1 row read in flight
    ST_L1     = 10'b0000001000, // l1 row valid: hit check
    ST_L2     = 10'b0000010000, // l2 row of access valid
    ST_EVL1   = 10'b0000100000, // l1 row of evicted l2 block in flight/valid
    ST_FILL1  = 10'b0001000000, // own l1 row re-read in flight
    ST_FILL1B = 10'b0010000000, // own l1 row valid, choose victim
    ST_WB2    = 10'b0100000000, // l2 row of dirty l1 victim valid
    ST_OUT    = 10'b1000000000
  } state_e;

  state_e state_q, state_d;

  // configuration, only while no access is in flight
  logic [LatW-1:0] l1_lat_q, l2_lat_q, mem_lat_q;
  logic            wr_alloc_q;
  assign cfg_ready_o = (state_q == ST_CLEAR) || (state_q == ST_IDLE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      l1_lat_q   <= LatW'(1);
      l2_lat_q   <= LatW'(10);
      mem_lat_q  <= LatW'(100);
      wr_alloc_q <= 1'b1;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_idx_e'(cfg_index_i))
        CFG_L1_LAT:   l1_lat_q   <= cfg_data_i[LatW-1:0];
        CFG_L2_LAT:   l2_lat_q   <= cfg_data_i[LatW-1:0];
        CFG_MEM_LAT:  mem_lat_q  <= cfg_data_i[LatW-1:0];
        CFG_WR_ALLOC: wr_alloc_q <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // set memories, one row per set
  l1_row_t l1_mem [L1Rows];
  l2_row_t l2_mem [L2Rows];
  logic [L1SetW-1:0] l1_addr;
  logic [L2SetW-1:0] l2_addr;
  logic              l1_we, l2_we;
  l1_row_t           l1_wdata, l1_rdata;
  l2_row_t           l2_wdata, l2_rdata;

  always_ff @(posedge clk_i) begin
    if (l1_we) l1_mem[l1_addr] <= l1_wdata;
    l1_rdata <= l1_mem[l1_addr];
  end
  always_ff @(posedge clk_i) begin
    if (l2_we) l2_mem[l2_addr] <= l2_wdata;
    l2_rdata <= l2_mem[l2_addr];
  end

  // access context
  logic              write_q;
  logic [BlockW-1:0] block_q;
  logic [BlockW-1:0] wbblk_q, wbblk_d;  // dirty l1 victim block
  logic [ClrW-1:0]   clr_q, clr_d;
  report_t           rep_q, rep_d;
  logic              write_d;
  logic [BlockW-1:0] block_d, evblk_q, evblk_d;
  logic              evl1_rd_q, evl1_rd_d;
  logic              out_v_q, out_v_d;
  logic [OutDataW-1:0] out_q, out_d;

  wire [L1SetW-1:0] s1 = L1SetW'(block_q[L1SetW-1:0] & L1SetW'(L1Rows - 1));
  wire [L2SetW-1:0] s2 = L2SetW'(block_q[L2SetW-1:0] & L2SetW'(L2Rows - 1));
  wire [L1TagW-1:0] t1 = block_q[BlockW-1 -: L1TagW];
  wire [L2TagW-1:0] t2 = block_q[BlockW-1 -: L2TagW];

  // lru helpers
  function automatic l1_row_t use1(l1_row_t r, logic [L1RankW-1:0] w);
    logic [L1RankW-1:0] old;
    l1_row_t o;
    old = r[w].rank;
    o = r;
    for (int i = 0; i < L1Ways; i++)
      if (i != int'(w) && r[i].rank > old) o[i].rank = r[i].rank - 1'b1;
    o[w].rank = L1RankW'(L1Ways - 1);
    return o;
  endfunction

  function automatic l2_row_t use2(l2_row_t r, logic [L2RankW-1:0] w);
    logic [L2RankW-1:0] old;
    l2_row_t o;
    old = r[w].rank;
    o = r;
    for (int i = 0; i < L2Ways; i++)
      if (i != int'(w) && r[i].rank > old) o[i].rank = r[i].rank - 1'b1;
    o[w].rank = L2RankW'(L2Ways - 1);
    return o;
  endfunction

  // victim pointer is the first rank-zero way, or way 0 when none (ranks
  // always keep one zero once a set has been used; reset ranks are all zero)
  function automatic logic [L1RankW-1:0] vic1(l1_row_t r);
    logic [L1RankW-1:0] v;
    v = '0;
    for (int i = L1Ways - 1; i >= 0; i--)
      if (r[i].rank == '0) v = L1RankW'(i);
    return v;
  endfunction

  function automatic logic [L2RankW-1:0] vic2(l2_row_t r);
    logic [L2RankW-1:0] v;
    v = '0;
    for (int i = L2Ways - 1; i >= 0; i--)
      if (r[i].rank == '0) v = L2RankW'(i);
    return v;
  endfunction

  logic              h1, h2, f1, f2, h1e;
  logic [L1RankW-1:0] w1, fw1, w1e;
  logic [L2RankW-1:0] w2, fw2;
  logic [L1TagW-1:0] et1;
  logic [L2TagW-1:0] wt2;

  always_comb begin
    h1 = 1'b0; w1 = '0; f1 = 1'b0; fw1 = '0;
    for (int i = L1Ways - 1; i >= 0; i--) begin
      if (l1_rdata[i].valid && l1_rdata[i].tag == t1) begin h1 = 1'b1; w1 = L1RankW'(i); end
      if (!l1_rdata[i].valid) begin f1 = 1'b1; fw1 = L1RankW'(i); end
    end
    et1 = evblk_q[BlockW-1 -: L1TagW];
    h1e = 1'b0; w1e = '0;
    for (int i = L1Ways - 1; i >= 0; i--)
      if (l1_rdata[i].valid && l1_rdata[i].tag == et1) begin h1e = 1'b1; w1e = L1RankW'(i); end
    h2 = 1'b0; w2 = '0; f2 = 1'b0; fw2 = '0;
    wt2 = wbblk_q[BlockW-1 -: L2TagW];
    for (int i = L2Ways - 1; i >= 0; i--) begin
      if (state_q == ST_WB2) begin
        if (l2_rdata[i].valid && l2_rdata[i].tag == wt2) begin h2 = 1'b1; w2 = L2RankW'(i); end
      end else if (l2_rdata[i].valid && l2_rdata[i].tag == t2) begin
        h2 = 1'b1; w2 = L2RankW'(i);
      end
      if (!l2_rdata[i].valid) begin f2 = 1'b1; fw2 = L2RankW'(i); end
    end
  end

  wire alloc = !write_q || wr_alloc_q;
  wire acc = s_axis_tvalid && s_axis_tready;
  // a configuration write offered in idle goes first
  assign s_axis_tready = (state_q == ST_IDLE) && !cfg_valid_i;

  l2_line_t vl2;
  l1_row_t  nr1;

  always_comb begin
    state_d  = state_q;
    clr_d    = clr_q;
    rep_d    = rep_q;
    write_d  = write_q;
    block_d  = block_q;
    evblk_d  = evblk_q;
    wbblk_d  = wbblk_q;
    evl1_rd_d = evl1_rd_q;
    out_v_d  = out_v_q;
    out_d    = out_q;
    l1_addr  = s1;
    l2_addr  = s2;
    l1_we    = 1'b0;
    l2_we    = 1'b0;
    l1_wdata = l1_rdata;
    l2_wdata = l2_rdata;
    vl2      = l2_rdata[0];
    nr1      = l1_rdata;

    if (out_v_q && m_axis_tready) out_v_d = 1'b0;

    unique case (state_q)
      ST_CLEAR: begin
        l1_addr  = L1SetW'(clr_q);
        l2_addr  = L2SetW'(clr_q);
        l1_wdata = '0;
        l2_wdata = '0;
        l1_we    = (clr_q < ClrW'(L1Rows));
        l2_we    = (clr_q < ClrW'(L2Rows));
        clr_d    = clr_q + 1'b1;
        if (clr_q == ClrW'(ClrRows - 1)) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        if (acc) begin
          write_d  = s_axis_tuser;
          block_d  = s_axis_tdata[AddressBits-1:BlockBytesLog2];
          state_d  = ST_RD1;
        end
      end
      ST_RD1: begin
        // read of own l1 and l2 rows issued with the address from block_q
        rep_d = '0;
        rep_d.cycles = CycW'(l1_lat_q);
        state_d = ST_L1;
      end
      ST_L1: begin
        if (h1) begin
          rep_d.l1_hit = 1'b1;
          l1_wdata = use1(l1_rdata, w1);
          if (write_q) l1_wdata[w1].dirty = 1'b1;
          l1_we   = 1'b1;
          state_d = ST_OUT;
        end else begin
          rep_d.cycles = rep_q.cycles + CycW'(l2_lat_q);
          state_d = ST_L2;
        end
      end
      ST_L2: begin
        if (h2) begin
          rep_d.l2_hit = 1'b1;
          l2_wdata = use2(l2_rdata, w2);
          if (!alloc) l2_wdata[w2].dirty = 1'b1;
          l2_we = 1'b1;
          state_d = alloc ? ST_FILL1 : ST_OUT;
        end else begin
          rep_d.mem = 2'd1;
          rep_d.cycles = rep_q.cycles + CycW'(mem_lat_q);
          if (!alloc) begin
            state_d = ST_OUT;
          end else begin
            l2_wdata = l2_rdata;
            if (f2) begin
              l2_wdata[fw2] = '{valid: 1'b1, dirty: 1'b0, tag: t2,
                                rank: l2_rdata[fw2].rank};
              l2_wdata = use2(l2_wdata, fw2);
              state_d = ST_FILL1;
            end else begin
              vl2 = l2_rdata[vic2(l2_rdata)];
              if (vl2.dirty) begin
                rep_d.l2_wb = 1'b1;
                rep_d.mem = 2'd2;
                rep_d.cycles = rep_q.cycles + CycW'(mem_lat_q) + CycW'(mem_lat_q);
              end
              evblk_d = BlockW'({vl2.tag, s2});
              l2_wdata[vic2(l2_rdata)] = '{valid: 1'b1, dirty: 1'b0, tag: t2,
                                           rank: vl2.rank};
              l2_wdata = use2(l2_wdata, vic2(l2_rdata));
              evl1_rd_d = 1'b0;
              state_d = ST_EVL1;
            end
            l2_we = 1'b1;
          end
        end
      end
      ST_EVL1: begin
        l1_addr = L1SetW'(evblk_q[L1SetW-1:0] & L1SetW'(L1Rows - 1));
        if (!evl1_rd_q) begin
          evl1_rd_d = 1'b1;
        end else begin
          if (h1e) begin
            l1_wdata = l1_rdata;
            l1_wdata[w1e] = '0;
            l1_we = 1'b1;
            rep_d.binv = 1'b1;
          end
          state_d = ST_FILL1;
        end
      end
      ST_FILL1: begin
        state_d = ST_FILL1B;
      end
      ST_FILL1B: begin
        nr1 = l1_rdata;
        if (f1) begin
          nr1[fw1] = '{valid: 1'b1, dirty: write_q, tag: t1, rank: l1_rdata[fw1].rank};
          nr1 = use1(nr1, fw1);
        end else begin
          if (l1_rdata[vic1(l1_rdata)].dirty) begin
            rep_d.l1_wb = 1'b1;
            wbblk_d = BlockW'({l1_rdata[vic1(l1_rdata)].tag, s1});
          end
          nr1[vic1(l1_rdata)] = '{valid: 1'b1, dirty: write_q, tag: t1,
                                  rank: l1_rdata[vic1(l1_rdata)].rank};
          nr1 = use1(nr1, vic1(l1_rdata));
        end
        l1_wdata = nr1;
        l1_we = 1'b1;
        if (!f1 && l1_rdata[vic1(l1_rdata)].dirty) begin
          l2_addr = L2SetW'(wbblk_d[L2SetW-1:0] & L2SetW'(L2Rows - 1));
          state_d = ST_WB2;
        end else begin
          state_d = ST_OUT;
        end
      end
      ST_WB2: begin
        l2_addr = L2SetW'(wbblk_q[L2SetW-1:0] & L2SetW'(L2Rows - 1));
        if (h2) begin
          l2_wdata = use2(l2_rdata, w2);
          l2_wdata[w2].dirty = 1'b1;
          l2_we = 1'b1;
        end
        state_d = ST_OUT;
      end
      ST_OUT: begin
        if (!out_v_q || m_axis_tready) begin
          out_v_d = 1'b1;
          out_d = OutDataW'({rep_q.cycles, rep_q.mem, rep_q.binv, rep_q.l2_wb,
                             rep_q.l1_wb, rep_q.l2_hit, rep_q.l1_hit});
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // on ST_FILL1 the own l1 row must be re-read; the default address does that
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_CLEAR;
      clr_q     <= '0;
      out_v_q   <= 1'b0;
      evl1_rd_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      clr_q     <= clr_d;
      out_v_q   <= out_v_d;
      evl1_rd_q <= evl1_rd_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rep_q   <= rep_d;
    write_q <= write_d;
    block_q <= block_d;
    evblk_q <= evblk_d;
    wbblk_q <= wbblk_d;
    out_q   <= out_d;
  end

  assign m_axis_tvalid = out_v_q;
  assign m_axis_tdata  = out_q;

  a_ready_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tready |-> !(state_q == ST_CLEAR)) else $error("ready during clear");
  a_hit_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_OUT) |-> !(rep_q.l1_hit && rep_q.l2_hit)) else $error("both hits");
  a_mem_hit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_OUT && rep_q.l1_hit) |-> (rep_q.mem == 2'd0 && !rep_q.l1_wb))
    else $error("hit with side effects");
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_v_q && !m_axis_tready) |=> $stable(out_q)) else $error("report changed");
endmodule
